// ----- hdl/cct_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the character-class tokenizer.
// No dependencies; used by char_class_tokenizer_core.
package cct_pkg;

    localparam logic [2:0] CLS_EXPR     = 3'd0;
    localparam logic [2:0] CLS_LINE     = 3'd1;
    localparam logic [2:0] CLS_NUMBER   = 3'd2;
    localparam logic [2:0] CLS_BRACKET  = 3'd3;
    localparam logic [2:0] CLS_OPERATOR = 3'd4;
    localparam logic [2:0] CLS_STRING   = 3'd5;
    localparam logic [2:0] CLS_NULL     = 3'd6;
    localparam logic [2:0] CLS_SPACE    = 3'd7;

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_STRING  = 2'd1;
    localparam logic [1:0] MODE_COMMENT = 2'd2;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_t;

    typedef struct packed {
        logic [7:0] token_byte;
        logic [2:0] token_class;
        logic       token_first;
        logic       token_last;
        logic       string_error;
    } token_t;

    function automatic logic [2:0] classify(input logic [7:0] b);
        logic [2:0] cls;
        case (b) inside
            [8'h61:8'h7A], [8'h41:8'h5A], 8'h5F, 8'hC3, 8'hB1, 8'h91: cls = CLS_EXPR;
            8'h3B, 8'h0A:                                            cls = CLS_LINE;
            8'h2E, [8'h30:8'h39]:                                    cls = CLS_NUMBER;
            8'h28, 8'h29:                                            cls = CLS_BRACKET;
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h25:                cls = CLS_OPERATOR;
            8'h20:                                                   cls = CLS_SPACE;
            8'h22:                                                   cls = CLS_STRING;
            default:                                                 cls = CLS_NULL;
        endcase
        return cls;
    endfunction

endpackage

// ----- hdl/char_class_tokenizer_core.sv -----
`timescale 1ns / 1ps
// Character-class tokenizer: byte stream in, classed token bytes out.
// Depends on cct_pkg for the channel structs, class codes and classify().
//
// Usage: source text enters on the text channel (text_valid / text_stall /
// text), one byte per transfer, with end_of_text set on the final byte.
// Kept bytes leave on the token channel (token_valid / token_stall / token)
// with their class and first/last marks. Space runs and comments are dropped.
// Each byte is held back until the next byte arrives, so that its last mark
// is known; the final byte of a text flushes both the held byte and itself.
// Throughput: one text byte per cycle while text_stall is low. A byte's
// result is written into a four-entry output queue at the edge that accepts
// the following byte (or at its own edge when end_of_text is set) and is
// offered on the token channel from the queue once it reaches the head.
// The text side is stalled whenever the queue has fewer than two free
// entries, since one transfer can produce two results. A stall on the token
// side holds the queue head; the text side runs on until fewer than two
// entries are free. Reset empties the queue and returns the lexer to normal
// mode with no held byte; the first byte after end_of_text starts a new text.
module char_class_tokenizer_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            text_valid,
    output logic            text_stall,
    input  cct_pkg::text_t  text,
    output logic            token_valid,
    input  logic            token_stall,
    output cct_pkg::token_t token
);

    typedef enum logic [1:0] {
        ACT_DROP,
        ACT_START,
        ACT_CONT
    } action_t;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam logic [QAW:0] QLIMIT = (QAW + 1)'(QDEPTH - 2);

    // lexer state
    logic [7:0] held_byte_reg;
    logic       held_valid_reg;
    logic [2:0] run_class_reg;
    logic [1:0] lex_mode_reg;
    logic       held_first_reg;

    logic [7:0] held_byte_next;
    logic       held_valid_next;
    logic [2:0] run_class_next;
    logic [1:0] lex_mode_next;
    logic       held_first_next;

    // output queue
    cct_pkg::token_t queue_reg [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]    count_reg, count_next;

    logic            accept;
    logic            pop;
    logic [1:0]      push_n;
    cct_pkg::token_t push0, push1;
    cct_pkg::token_t res_held, res_final;
    logic            res_held_valid, res_final_valid;

    logic [7:0] b;
    logic [1:0] mode;
    logic [1:0] mode_new;
    logic [2:0] cls;
    action_t    action;
    logic       decided;
    logic       err;
    logic       nv_valid;
    logic [2:0] nv_class;
    logic       nv_first;

    assign text_stall  = (count_reg > QLIMIT);
    assign accept      = text_valid & ~text_stall;
    assign token_valid = (count_reg != '0);
    assign token       = queue_reg[rd_ptr_reg];
    assign pop         = token_valid & ~token_stall;

    always_comb
    begin
        b        = text.text_byte;
        mode     = (lex_mode_reg > cct_pkg::MODE_COMMENT) ? cct_pkg::MODE_NORMAL
                                                          : lex_mode_reg;
        mode_new = mode;
        cls      = cct_pkg::CLS_SPACE;
        action   = ACT_DROP;
        decided  = 1'b0;

        if (mode == cct_pkg::MODE_COMMENT)
        begin
            if (b == cct_pkg::CH_NEWLINE)
                mode_new = cct_pkg::MODE_NORMAL;
            else
                decided = 1'b1;
        end
        else if (mode == cct_pkg::MODE_STRING)
        begin
            cls     = cct_pkg::CLS_STRING;
            action  = held_valid_reg ? ACT_CONT : ACT_START;
            decided = 1'b1;
            if (b == cct_pkg::CH_QUOTE)
                mode_new = cct_pkg::MODE_NORMAL;
        end

        if (!decided)
        begin
            if (b == cct_pkg::CH_HASH)
                mode_new = cct_pkg::MODE_COMMENT;
            else
            begin
                cls = cct_pkg::classify(b);
                if (cls == cct_pkg::CLS_SPACE)
                    action = ACT_DROP;
                else if (cls == cct_pkg::CLS_STRING)
                begin
                    action   = ACT_START;
                    mode_new = cct_pkg::MODE_STRING;
                end
                else if (held_valid_reg && run_class_reg == cls &&
                         cls != cct_pkg::CLS_BRACKET)
                    action = ACT_CONT;
                else
                    action = ACT_START;
            end
        end

        err = text.end_of_text && (mode_new == cct_pkg::MODE_STRING);

        // the byte now held back flushes with its last mark settled
        res_held_valid        = held_valid_reg;
        res_held.token_byte   = held_byte_reg;
        res_held.token_class  = run_class_reg;
        res_held.token_first  = held_first_reg;
        res_held.token_last   = (action != ACT_CONT);
        res_held.string_error = err;

        nv_valid = (action != ACT_DROP);
        nv_class = nv_valid ? cls : cct_pkg::CLS_SPACE;
        nv_first = (action != ACT_CONT);

        res_final_valid        = text.end_of_text && nv_valid;
        res_final.token_byte   = b;
        res_final.token_class  = nv_class;
        res_final.token_first  = nv_first;
        res_final.token_last   = 1'b1;
        res_final.string_error = err;

        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        run_class_next  = run_class_reg;
        lex_mode_next   = lex_mode_reg;
        held_first_next = held_first_reg;
        push_n          = 2'd0;
        push0           = res_held;
        push1           = res_final;

        if (accept)
        begin
            if (text.end_of_text)
            begin
                // end of text: back to the reset state for the next text
                held_byte_next  = '0;
                held_valid_next = 1'b0;
                run_class_next  = cct_pkg::CLS_SPACE;
                lex_mode_next   = cct_pkg::MODE_NORMAL;
                held_first_next = 1'b1;
            end
            else
            begin
                held_byte_next  = nv_valid ? b : held_byte_reg;
                held_valid_next = nv_valid;
                run_class_next  = nv_class;
                lex_mode_next   = mode_new;
                held_first_next = nv_first;
            end
            push_n = {1'b0, res_held_valid} + {1'b0, res_final_valid};
            if (!res_held_valid)
                push0 = res_final;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QAW'(push_n);
        rd_ptr_next = rd_ptr_reg + QAW'(pop);
        count_next  = count_reg + (QAW + 1)'(push_n) - (QAW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            run_class_reg  <= cct_pkg::CLS_SPACE;
            lex_mode_reg   <= cct_pkg::MODE_NORMAL;
            held_first_reg <= 1'b1;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            run_class_reg  <= run_class_next;
            lex_mode_reg   <= lex_mode_next;
            held_first_reg <= held_first_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
        end
    end

    // queue storage: up to two writes per transfer, no reset needed
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            queue_reg[wr_ptr_reg] <= push0;
        if (push_n == 2'd2)
            queue_reg[wr_ptr_reg + QAW'(1)] <= push1;
    end

endmodule
